// File: rtl/mpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_pkg
// Shared types and constants of the monochrome page framebuffer flush block.
// ----------------------------------------------------------------------------
package mpf_pkg;

    // Operation codes, in the same order as the input kind field.
    typedef enum logic [1:0] {
        OP_PLOT  = 2'd0,
        OP_FILL  = 2'd1,
        OP_START = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    // Configuration register indexes.
    localparam logic CFG_INVERT = 1'b0;
    localparam logic CFG_PAD    = 1'b1;

    // Panel command and data byte values.
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [7:0] PAD_BYTE      = 8'h00;
    localparam logic [7:0] FILL_WHITE    = 8'hFF;
    localparam logic [7:0] FILL_BLACK    = 8'h00;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Classified command held in the queue. Fields are sized for the largest
    // panel; the back end takes the bits that its geometry needs.
    typedef struct packed {
        t_op        op;
        logic [7:0] col;
        logic [3:0] page;
        logic [2:0] bit_idx;
        logic       colour;
    } t_cmd;

    // Status from the back end to the front end.
    typedef struct packed {
        logic init_busy;
    } t_back_status;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_FILL     = 3'd1,
        ST_PLOT_WR  = 3'd2,
        ST_TICK_OUT = 3'd3
    } t_state;

endpackage

// File: rtl/mpf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_front
// Accepts input beats, drops plots outside the panel and turns the rest into
// queue commands with the colour inversion already applied.
// ----------------------------------------------------------------------------
module mpf_front #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64
) (
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_kind,
    input  logic [7:0]           i_x_pos,
    input  logic [7:0]           i_y_pos,
    input  logic                 i_colour,
    input  logic                 i_invert,
    input  mpf_pkg::t_back_status i_status,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output mpf_pkg::t_cmd        o_q_cmd
);
    import mpf_pkg::*;

    logic  in_range;
    logic  keep;
    t_op   op;

    // Hold off the source while the queue is full or the store is cleared after reset.
    assign o_stall = i_q_full | i_status.init_busy;

    // A plot outside the panel leaves no trace.
    assign op       = t_op'(i_kind);
    assign in_range = ({1'b0, i_x_pos} < 9'(PANEL_WIDTH)) &&
                      ({1'b0, i_y_pos} < 9'(PANEL_HEIGHT));
    assign keep     = (op != OP_PLOT) || in_range;
    assign o_q_push = i_valid && !o_stall && keep;

    // Build the command. Inversion applies to plots only.
    always_comb begin
        o_q_cmd.op      = op;
        o_q_cmd.col     = i_x_pos;
        o_q_cmd.page    = i_y_pos[6:3];
        o_q_cmd.bit_idx = i_y_pos[2:0];
        o_q_cmd.colour  = (op == OP_PLOT) ? (i_colour ^ i_invert) : i_colour;
    end

endmodule

// File: rtl/mpf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module mpf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mpf_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output mpf_pkg::t_cmd o_head,
    input  logic          i_pop
);
    import mpf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill level update, wrapping at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: rtl/mpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_back
// Executes queued commands on the frame store: pixel read-modify-write, fill
// sweeps, flush start and one byte per flush tick into the output register.
// ----------------------------------------------------------------------------
module mpf_back #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  mpf_pkg::t_cmd         i_q_head,
    output logic                  o_q_pop,
    input  logic                  i_pad_mode,
    output mpf_pkg::t_back_status o_status,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_panel_byte,
    output logic                  o_is_data,
    output logic                  o_frame_end
);
    import mpf_pkg::*;

    localparam int STORE_PAGES = (PANEL_HEIGHT + 7) / 8;
    localparam int FLUSH_PAGES = PANEL_HEIGHT / 8;
    localparam int PW          = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;
    localparam int CW          = $clog2(PANEL_WIDTH);
    localparam int AW          = PW + CW;
    localparam int DEPTH       = 1 << AW;
    localparam int SW          = $clog2(PANEL_WIDTH + 8);

    // Sequencer state.
    t_state r_state, n_state;
    logic   r_init, n_init;

    // Fill sweep.
    logic [AW-1:0] r_sweep, n_sweep;
    logic [7:0]    r_fill_val, n_fill_val;

    // Command under execution.
    t_cmd r_cmd, n_cmd;

    // Flush position.
    logic          r_flushing, n_flushing;
    logic          r_pad, n_pad;
    logic [PW-1:0] r_page, n_page;
    logic [SW-1:0] r_step, n_step;

    // Output register.
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_data, n_out_data;
    logic       r_out_end, n_out_end;

    // Store port.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // Flush byte decode.
    logic [SW-1:0] data_start;
    logic [SW-1:0] data_col;
    logic [SW-1:0] step_last;
    logic          in_data;
    logic          last_step;
    logic          last_page;
    logic [AW-1:0] tick_addr;
    logic [AW-1:0] head_addr;
    logic [AW-1:0] cmd_addr;
    logic [7:0]    bit_mask;
    logic [7:0]    tick_byte;
    logic          tick_is_data;
    logic          out_free;
    logic          sweep_last;

    mpf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Position of the current flush byte within its page.
    assign data_start = SW'(3) + (r_pad ? SW'(2) : SW'(0));
    assign data_col   = r_step - data_start;
    assign in_data    = (r_step >= data_start) && (data_col < SW'(PANEL_WIDTH));
    assign step_last  = SW'(PANEL_WIDTH + 2) + (r_pad ? SW'(4) : SW'(0));
    assign last_step  = (r_step == step_last);
    assign last_page  = (r_page == PW'(FLUSH_PAGES - 1));

    // Store addresses: page in the upper bits, column in the lower bits.
    assign tick_addr = {r_page, data_col[CW-1:0]};
    assign head_addr = {i_q_head.page[PW-1:0], i_q_head.col[CW-1:0]};
    assign cmd_addr  = {r_cmd.page[PW-1:0], r_cmd.col[CW-1:0]};
    assign bit_mask  = 8'b1 << r_cmd.bit_idx;

    assign sweep_last = (r_sweep == '1);
    assign out_free   = !r_out_valid || !i_stall;
    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid;

    // Byte for the current flush step: three commands, then data or padding.
    always_comb begin
        tick_is_data = 1'b0;
        unique case (r_step)
            SW'(0):  tick_byte = CMD_PAGE_BASE + 8'(r_page);
            SW'(1):  tick_byte = CMD_COL_LOW;
            SW'(2):  tick_byte = CMD_COL_HIGH;
            default: begin
                tick_is_data = 1'b1;
                tick_byte    = in_data ? ram_rdata : PAD_BYTE;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_head.op)
                        OP_PLOT:  n_state = ST_PLOT_WR;
                        OP_FILL:  n_state = ST_FILL;
                        OP_START: n_state = ST_IDLE;
                        OP_TICK:  n_state = r_flushing ? ST_TICK_OUT : ST_IDLE;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PLOT_WR: n_state = ST_IDLE;
            ST_TICK_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and store control.
    always_comb begin
        n_init      = r_init;
        n_sweep     = r_sweep;
        n_fill_val  = r_fill_val;
        n_cmd       = r_cmd;
        n_flushing  = r_flushing;
        n_pad       = r_pad;
        n_page      = r_page;
        n_step      = r_step;
        n_out_byte  = r_out_byte;
        n_out_data  = r_out_data;
        n_out_end   = r_out_end;
        n_out_valid = r_out_valid && i_stall;
        ram_we      = 1'b0;
        ram_waddr   = cmd_addr;
        ram_wdata   = r_cmd.colour ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
        ram_raddr   = tick_addr;

        unique case (r_state)
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep;
                ram_wdata = r_fill_val;
                n_sweep   = r_sweep + 1'b1;
                if (sweep_last) begin
                    n_init = 1'b0;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_cmd = i_q_head;
                    if (i_q_head.op == OP_PLOT) begin
                        ram_raddr = head_addr;
                    end
                    if (i_q_head.op == OP_FILL) begin
                        n_sweep    = '0;
                        n_fill_val = i_q_head.colour ? FILL_WHITE : FILL_BLACK;
                    end
                    if ((i_q_head.op == OP_START) && !r_flushing) begin
                        n_flushing = 1'b1;
                        n_pad      = i_pad_mode;
                        n_page     = '0;
                        n_step     = '0;
                    end
                end
            end
            ST_PLOT_WR: begin
                ram_we = 1'b1;
            end
            ST_TICK_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = tick_byte;
                    n_out_data  = tick_is_data;
                    n_out_end   = last_step && last_page;
                    if (last_step) begin
                        n_step = '0;
                        if (last_page) begin
                            n_page     = '0;
                            n_flushing = 1'b0;
                        end else begin
                            n_page = r_page + 1'b1;
                        end
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_stall;
            end
        endcase
    end

    // Control registers; reset starts the clearing sweep with black.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_init      <= 1'b1;
            r_sweep     <= '0;
            r_fill_val  <= FILL_BLACK;
            r_flushing  <= 1'b0;
            r_pad       <= 1'b0;
            r_page      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_sweep     <= n_sweep;
            r_fill_val  <= n_fill_val;
            r_flushing  <= n_flushing;
            r_pad       <= n_pad;
            r_page      <= n_page;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out_byte <= n_out_byte;
        r_out_data <= n_out_data;
        r_out_end  <= n_out_end;
    end

    assign o_status.init_busy = r_init;
    assign o_valid            = r_out_valid;
    assign o_panel_byte       = r_out_byte;
    assign o_is_data          = r_out_data;
    assign o_frame_end        = r_out_end;

    // The closing byte of a flush is always a data byte.
    a_end_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |-> r_out_data)
        else $error("frame end marked on a command byte");

    // No command is taken from the queue during a sweep.
    a_no_pop_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) |-> !o_q_pop)
        else $error("queue popped during a fill sweep");

    // The store is written only by a sweep or by the write half of a plot.
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == ST_FILL) || (r_state == ST_PLOT_WR)))
        else $error("unexpected store write");

    // Emitting the closing byte ends the flush.
    a_end_stops_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_TICK_OUT) && out_free && last_step && last_page)
        |=> (!r_flushing && r_out_end))
        else $error("flush still running after its last byte");

    // A tick is executed only while a flush runs.
    a_tick_needs_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK_OUT) |-> r_flushing)
        else $error("byte emitted outside a flush");

endmodule

// File: rtl/mono_page_framebuffer_flush.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_page_framebuffer_flush
// Page-organised 1-bit framebuffer with a panel flush byte sequencer.
// ----------------------------------------------------------------------------
// Beats enter a two-entry command queue and run one at a time on the frame
// store, a single RAM with one write and one registered read port. A pixel
// plot is a read-modify-write of one store byte, read when it is popped and
// written in the state after; a tick during a flush reads one byte and may
// wait while the output register is stalled; a flush start or an idle tick
// is finished when it is popped. A fill is decoded when it is popped and
// then writes the whole store at one byte per cycle through the write port,
// 1024 bytes for a 128 x 64 panel. After reset the same sweep clears the
// store to black, and the input stays stalled until the sweep ends;
// configuration writes are taken throughout. Up to two further beats are
// queued while a command runs.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_flush #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input beats.
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_x_pos,
    input  logic [7:0] i_y_pos,
    input  logic       i_colour,
    // Panel byte beats.
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_panel_byte,
    output logic       o_is_data,
    output logic       o_frame_end,
    // Configuration writes.
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic       i_cfg_data
);
    import mpf_pkg::*;

    logic         r_invert;
    logic         r_pad_mode;
    logic         q_push;
    logic         q_full;
    logic         q_valid;
    logic         q_pop;
    t_cmd         q_cmd;
    t_cmd         q_head;
    t_back_status back_status;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert   <= 1'b0;
            r_pad_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INVERT: r_invert   <= i_cfg_data;
                CFG_PAD:    r_pad_mode <= i_cfg_data;
                default:    r_invert   <= r_invert;
            endcase
        end
    end

    mpf_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_kind   (i_kind),
        .i_x_pos  (i_x_pos),
        .i_y_pos  (i_y_pos),
        .i_colour (i_colour),
        .i_invert (r_invert),
        .i_status (back_status),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_cmd)
    );

    mpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    mpf_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_head     (q_head),
        .o_q_pop      (q_pop),
        .i_pad_mode   (r_pad_mode),
        .o_status     (back_status),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_panel_byte (o_panel_byte),
        .o_is_data    (o_is_data),
        .o_frame_end  (o_frame_end)
    );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the monochrome page framebuffer flush block.
// ----------------------------------------------------------------------------
// A mirror of the frame store and of the flush sequencer predicts each panel
// byte as input beats are accepted. Plots, fills, flush starts and ticks are
// driven from a queue filled in phases: a short directed phase, then random
// phases that mix plots and fills with long runs of ticks so that flushes
// advance deep into the frame in both padded and plain modes. Registers are
// rewritten between phases, sometimes in the middle of a flush.
// ----------------------------------------------------------------------------
module testbench;
    import mpf_pkg::*;

    localparam int PANEL_W       = 128;
    localparam int PANEL_H       = 64;
    localparam int STORE_PAGES   = (PANEL_H + 7) / 8;
    localparam int FLUSH_PAGES   = PANEL_H / 8;
    localparam int STORE_BYTES   = PANEL_W * STORE_PAGES;
    // Up to three fills may still be running: one executing and two queued.
    localparam int SETTLE_CYCLES = 3300;

    typedef struct packed {
        t_op        op;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic       colour;
    } t_item;

    typedef struct packed {
        logic [7:0] panel_byte;
        logic       is_data;
        logic       frame_end;
    } t_panel_beat;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic       o_stall;
    logic [1:0] i_kind     = OP_TICK;
    logic [7:0] i_x_pos    = 8'd0;
    logic [7:0] i_y_pos    = 8'd0;
    logic       i_colour   = 1'b0;
    logic       o_valid;
    logic       i_stall    = 1'b0;
    logic [7:0] o_panel_byte;
    logic       o_is_data;
    logic       o_frame_end;
    logic       i_cfg_we   = 1'b0;
    logic       i_cfg_idx  = CFG_INVERT;
    logic       i_cfg_data = 1'b0;

    // Stimulus and prediction state.
    t_item       pending_items[$];
    t_panel_beat expected_beats[$];
    t_item       next_item;
    t_panel_beat got_beat;
    t_panel_beat want_beat;
    int          items_pushed = 0;
    int          items_taken  = 0;
    int          error_count  = 0;
    logic        in_taken     = 1'b0;
    logic        calm;

    // Mirror of the block.
    logic [7:0]  store_mirror[STORE_BYTES];
    logic [2:0]  flush_page   = '0;
    int          flush_step   = 0;
    logic        flushing     = 1'b0;
    logic        pad_latched  = 1'b0;
    logic        invert_reg   = 1'b0;
    logic        pad_reg      = 1'b0;

    mono_page_framebuffer_flush #(
        .PANEL_WIDTH  (PANEL_W),
        .PANEL_HEIGHT (PANEL_H)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .i_colour     (i_colour),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_panel_byte (o_panel_byte),
        .o_is_data    (o_is_data),
        .o_frame_end  (o_frame_end),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Updates the mirror for one accepted beat and queues the panel byte it
    // causes, if any.
    task automatic predict_panel_beats(input t_item it);
        int          idx;
        int          col;
        int          lead;
        int          page_len;
        logic        last_step;
        logic        last_page;
        t_panel_beat pb;
        case (it.op)
            OP_PLOT: begin
                if (it.x_pos < PANEL_W && it.y_pos < PANEL_H) begin
                    idx = it.x_pos + (it.y_pos / 8) * PANEL_W;
                    store_mirror[idx][it.y_pos % 8] = it.colour ^ invert_reg;
                end
            end
            OP_FILL: begin
                foreach (store_mirror[i]) store_mirror[i] = it.colour ? FILL_WHITE : FILL_BLACK;
            end
            OP_START: begin
                if (!flushing) begin
                    flushing    = 1'b1;
                    flush_page  = '0;
                    flush_step  = 0;
                    pad_latched = pad_reg;
                end
            end
            default: begin
                if (flushing) begin
                    lead     = pad_latched ? 2 : 0;
                    page_len = 3 + PANEL_W + 2 * lead;
                    pb.is_data = 1'b0;
                    if (flush_step == 0) begin
                        pb.panel_byte = CMD_PAGE_BASE + flush_page;
                    end else if (flush_step == 1) begin
                        pb.panel_byte = CMD_COL_LOW;
                    end else if (flush_step == 2) begin
                        pb.panel_byte = CMD_COL_HIGH;
                    end else begin
                        col        = flush_step - 3;
                        pb.is_data = 1'b1;
                        if (col < lead || col - lead >= PANEL_W) begin
                            pb.panel_byte = PAD_BYTE;
                        end else begin
                            pb.panel_byte = store_mirror[flush_page * PANEL_W + col - lead];
                        end
                    end
                    last_step    = (flush_step + 1 >= page_len);
                    last_page    = (flush_page + 1 >= FLUSH_PAGES);
                    pb.frame_end = last_step && last_page;
                    expected_beats.push_back(pb);
                    if (last_step) begin
                        flush_step = 0;
                        if (last_page) begin
                            flush_page = '0;
                            flushing   = 1'b0;
                        end else begin
                            flush_page = flush_page + 1'b1;
                        end
                    end else begin
                        flush_step = flush_step + 1;
                    end
                end
            end
        endcase
    endtask

    // Input beats are predicted as they are accepted; panel beats are checked.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && (o_stall === 1'b0);
        if (i_rst_n && i_valid && (o_stall === 1'b0)) begin
            predict_panel_beats(t_item'({t_op'(i_kind), i_x_pos, i_y_pos, i_colour}));
            items_taken <= items_taken + 1;
        end
        if (i_rst_n && (o_valid === 1'b1) && !i_stall) begin
            got_beat = {o_panel_byte, o_is_data, o_frame_end};
            if (expected_beats.size() == 0) begin
                error_count = error_count + 1;
                if (error_count <= 10)
                    $display("unexpected panel beat: byte %h data %b end %b",
                             o_panel_byte, o_is_data, o_frame_end);
            end else begin
                want_beat = expected_beats.pop_front();
                if (got_beat !== want_beat) begin
                    error_count = error_count + 1;
                    if (error_count <= 10)
                        $display("panel beat mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 want_beat.panel_byte, want_beat.is_data,
                                 want_beat.frame_end, o_panel_byte, o_is_data,
                                 o_frame_end);
                end
            end
        end
    end

    // No idling on either side for a long stretch of the run.
    assign calm = (items_taken >= 200) && (items_taken < 320);

    // Input driver and output stall, both moving at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
                next_item = pending_items.pop_front();
                i_valid  <= 1'b1;
                i_kind   <= next_item.op;
                i_x_pos  <= next_item.x_pos;
                i_y_pos  <= next_item.y_pos;
                i_colour <= next_item.colour;
            end else begin
                i_valid  <= 1'b0;
            end
        end
        i_stall <= !calm && ($urandom_range(0, 99) < 15);
    end

    task automatic queue_item(input t_op op, input int x, input int y, input logic colour);
        pending_items.push_back(t_item'({op, 8'(x), 8'(y), colour}));
        items_pushed = items_pushed + 1;
    endtask

    // Pixel plots land mostly inside the panel, the rest anywhere.
    task automatic queue_random_plot();
        if ($urandom_range(0, 99) < 85)
            queue_item(OP_PLOT, $urandom_range(0, PANEL_W - 1), $urandom_range(0, PANEL_H - 1),
                       1'($urandom_range(0, 1)));
        else
            queue_item(OP_PLOT, $urandom_range(0, 255), $urandom_range(0, 255),
                       1'($urandom_range(0, 1)));
    endtask

    task automatic queue_random_other(input t_op op);
        queue_item(op, $urandom_range(0, 255), $urandom_range(0, 255), 1'($urandom_range(0, 1)));
    endtask

    task automatic write_reg(input logic idx, input logic val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_INVERT) invert_reg = val;
        else pad_reg = val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Waits until every queued beat has gone in and every panel byte is out,
    // then lets any fills still running finish.
    task automatic settle();
        @(negedge i_clk);
        while (items_taken != items_pushed || expected_beats.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // A sweep phase is mostly ticks so that the flush advances far; near its
    // end it issues another flush start, so the next phase may open mid-flush.
    task automatic run_phase(input logic inv, input logic pad, input logic sweep, input int n);
        int r;
        write_reg(CFG_INVERT, inv);
        write_reg(CFG_PAD, pad);
        if (sweep) queue_random_other(OP_START);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (sweep && i == n - 20) begin
                queue_random_other(OP_START);
            end else if (sweep) begin
                if (r < 4) queue_random_plot();
                else queue_random_other(OP_TICK);
            end else begin
                if (r < 2) queue_random_other(OP_FILL);
                else if (r < 10) queue_random_other(OP_START);
                else if (r < 50) queue_random_plot();
                else queue_random_other(OP_TICK);
            end
        end
        settle();
    endtask

    // Main sequence.
    initial begin
        foreach (store_mirror[i]) store_mirror[i] = 8'h00;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_INVERT, 1'b0);
        write_reg(CFG_PAD, 1'b0);

        // Directed: idle tick, corner and out-of-panel plots, a repeated
        // start, then a fill and a plot while the flush is running.
        queue_item(OP_TICK, 0, 0, 1'b0);
        queue_item(OP_PLOT, 0, 0, 1'b1);
        queue_item(OP_PLOT, PANEL_W - 1, PANEL_H - 1, 1'b1);
        queue_item(OP_PLOT, PANEL_W, 0, 1'b1);
        queue_item(OP_PLOT, 0, PANEL_H, 1'b1);
        queue_item(OP_PLOT, 255, 255, 1'b1);
        queue_item(OP_PLOT, 5, 9, 1'b1);
        queue_item(OP_PLOT, 5, 9, 1'b0);
        queue_item(OP_PLOT, 5, 10, 1'b1);
        queue_item(OP_PLOT, PANEL_W - 1, 0, 1'b1);
        queue_item(OP_START, 0, 0, 1'b0);
        queue_item(OP_START, 255, 255, 1'b1);
        repeat (5) queue_item(OP_TICK, 255, 0, 1'b1);
        queue_item(OP_FILL, 0, 255, 1'b1);
        queue_item(OP_PLOT, 3, 0, 1'b0);
        repeat (3) queue_item(OP_TICK, 0, 255, 1'b0);
        settle();

        run_phase(1'b1, 1'b0, 1'b0, 70);
        run_phase(1'b0, 1'b1, 1'b1, 130);
        run_phase(1'b1, 1'b1, 1'b0, 70);
        run_phase(1'b0, 1'b0, 1'b1, 130);
        run_phase(1'b1, 1'b1, 1'b1, 80);
        run_phase(1'b0, 1'b1, 1'b0, 40);

        error_count = error_count + expected_beats.size();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #3_200_000;
        $display("status: fail");
        $finish;
    end

endmodule
